/* hdl/space_packet_byte_deframer_macros.svh */
// assertion macros used by the deframer core
`ifndef SPACE_PACKET_BYTE_DEFRAMER_MACROS_SVH
`define SPACE_PACKET_BYTE_DEFRAMER_MACROS_SVH

// condition holds in every cycle out of reset
`define SPBD_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define SPBD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define SPBD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/spbd_pkg.sv */
// package with types and constants of the space packet byte deframer
`default_nettype none

package spbd_pkg;

    // primary header length in bytes
    localparam int unsigned HEADER_BYTES = 6;
    localparam int unsigned HDR_IDX_W    = 3;
    localparam int unsigned TIMEOUT_W    = 16;
    localparam int unsigned LENGTH_W     = 16;
    localparam int unsigned REMAIN_W     = LENGTH_W + 1;
    localparam int unsigned BYTE_W       = 8;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(1000);
    localparam logic [HDR_IDX_W-1:0] HDR_LAST_IDX  = HDR_IDX_W'(HEADER_BYTES - 1);

    typedef enum logic
    {
        MODE_BYTE = 1'b0,
        MODE_TICK = 1'b1
    } spbd_mode_t;

    typedef enum logic
    {
        KIND_BYTE  = 1'b0,
        KIND_ABORT = 1'b1
    } spbd_kind_t;

    typedef struct packed
    {
        spbd_mode_t          mode;
        logic [BYTE_W-1:0]   data;
    } spbd_item_t;

    typedef struct packed
    {
        spbd_kind_t          kind;
        logic [BYTE_W-1:0]   byte_out;
        logic                last;
        logic                in_header;
    } spbd_result_t;

endpackage

`default_nettype wire

/* hdl/spbd_channels.sv */
// channel interfaces of the deframer: input items, result items, config writes
`default_nettype none

interface spbd_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] data;

    modport source (output valid, output mode, output data, input ready);
    modport sink   (input valid, input mode, input data, output ready);
endinterface

interface spbd_out_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] byte_out;
    logic       last;
    logic       in_header;

    modport source (output valid, output kind, output byte_out, output last,
                    output in_header, input ready);
    modport sink   (input valid, input kind, input byte_out, input last,
                    input in_header, output ready);
endinterface

interface spbd_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hdl/space_packet_byte_deframer.sv */
// top level of the space packet byte deframer
//
//  channel  dir  handshake     payload
//  in       in   valid/ready   mode, data
//  out      out  valid/ready   kind, byte_out, last, in_header
//  cfg      in   valid/ready   data (timeout_ticks)
//
// one item per cycle sustained while the output is not stalled; a result passes the
// input register, then the output register after the parser update, before it is offered
// cfg is always ready and loads the timeout register
// reset clears the parser and watchdog and sets the timeout to 1000 ticks
// a stalled output holds its result; ticks that give no result pass through
// without waiting for the output side
`default_nettype none

module space_packet_byte_deframer
(
    input  wire        clk,
    input  wire        rst_n,
    spbd_in_if.sink    in,
    spbd_out_if.source out,
    spbd_cfg_if.sink   cfg
);

    spbd_pkg::spbd_item_t   up_item;
    spbd_pkg::spbd_item_t   item;
    spbd_pkg::spbd_result_t res;
    spbd_pkg::spbd_result_t dn_res;
    logic                   item_valid;
    logic                   advance;
    logic                   res_valid;
    logic                   res_ready;

    // config channel never stalls
    assign cfg.ready = 1'b1;

    // input payload
    assign up_item.mode = spbd_pkg::spbd_mode_t'(in.mode);
    assign up_item.data = in.data;

    spbd_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (in.valid),
        .up_ready   (in.ready),
        .up_item    (up_item),
        .item_valid (item_valid),
        .item       (item),
        .advance    (advance)
    );

    spbd_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg.valid),
        .cfg_data   (cfg.data),
        .item_valid (item_valid),
        .item       (item),
        .advance    (advance),
        .res_ready  (res_ready),
        .res_valid  (res_valid),
        .res        (res)
    );

    spbd_out_stage u_out_stage
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .dn_valid  (out.valid),
        .dn_ready  (out.ready),
        .dn_res    (dn_res)
    );

    // output payload
    assign out.kind      = dn_res.kind;
    assign out.byte_out  = dn_res.byte_out;
    assign out.last      = dn_res.last;
    assign out.in_header = dn_res.in_header;

endmodule

`default_nettype wire

/* hdl/spbd_in_stage.sv */
// input register holding one accepted item for the parser
`default_nettype none

module spbd_in_stage
(
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 up_valid,
    output logic                up_ready,
    input  spbd_pkg::spbd_item_t up_item,
    output logic                item_valid,
    output spbd_pkg::spbd_item_t item,
    input  wire                 advance
);

    logic                 valid_reg;
    logic                 valid_next;
    spbd_pkg::spbd_item_t item_reg;

    // free slot when empty or when the held item moves on this cycle
    assign up_ready   = !valid_reg || advance;
    assign valid_next = up_ready ? up_valid : valid_reg;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            item_reg <= up_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

/* hdl/spbd_core.sv */
// header and payload counters, length capture and watchdog
`default_nettype none

`include "space_packet_byte_deframer_macros.svh"

module spbd_core
(
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   cfg_valid,
    input  wire [spbd_pkg::TIMEOUT_W-1:0]         cfg_data,
    input  wire                                   item_valid,
    input  spbd_pkg::spbd_item_t                  item,
    output logic                                  advance,
    input  wire                                   res_ready,
    output logic                                  res_valid,
    output spbd_pkg::spbd_result_t                res
);

    logic [spbd_pkg::TIMEOUT_W-1:0] timeout_reg;
    logic [spbd_pkg::HDR_IDX_W-1:0] header_index_reg, header_index_next;
    logic [spbd_pkg::LENGTH_W-1:0]  length_shift_reg, length_shift_next;
    logic [spbd_pkg::REMAIN_W-1:0]  bytes_remaining_reg, bytes_remaining_next;
    logic [spbd_pkg::TIMEOUT_W-1:0] watchdog_count_reg, watchdog_count_next;
    logic                           watchdog_running_reg, watchdog_running_next;
    logic                           produce;
    logic                           expire;

    // timeout register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= spbd_pkg::TIMEOUT_RESET;
        end
        else if (cfg_valid)
        begin
            timeout_reg <= cfg_data;
        end
    end

    assign expire = watchdog_running_reg && (watchdog_count_reg <= spbd_pkg::TIMEOUT_W'(1));

    // next state and result for the held item
    always_comb
    begin
        header_index_next     = header_index_reg;
        length_shift_next     = length_shift_reg;
        bytes_remaining_next  = bytes_remaining_reg;
        watchdog_count_next   = watchdog_count_reg;
        watchdog_running_next = watchdog_running_reg;
        produce               = 1'b0;
        res.kind              = spbd_pkg::KIND_BYTE;
        res.byte_out          = '0;
        res.last              = 1'b0;
        res.in_header         = 1'b0;

        if (item.mode == spbd_pkg::MODE_TICK)
        begin
            if (expire)
            begin
                // abort of a partial packet
                produce               = 1'b1;
                res.kind              = spbd_pkg::KIND_ABORT;
                watchdog_count_next   = '0;
                watchdog_running_next = 1'b0;
                header_index_next     = '0;
                bytes_remaining_next  = '0;
            end
            else if (watchdog_running_reg)
            begin
                watchdog_count_next = watchdog_count_reg - spbd_pkg::TIMEOUT_W'(1);
            end
        end
        else
        begin
            produce           = 1'b1;
            res.byte_out      = item.data;
            length_shift_next = {length_shift_reg[spbd_pkg::BYTE_W-1:0], item.data};

            if (bytes_remaining_reg != '0)
            begin
                // payload byte
                bytes_remaining_next = bytes_remaining_reg - spbd_pkg::REMAIN_W'(1);
                res.last             = (bytes_remaining_reg == spbd_pkg::REMAIN_W'(1));
            end
            else
            begin
                // header byte, the sixth one loads the payload count
                res.in_header = 1'b1;
                if (header_index_reg == spbd_pkg::HDR_LAST_IDX)
                begin
                    header_index_next    = '0;
                    bytes_remaining_next = {1'b0, length_shift_next}
                                           + spbd_pkg::REMAIN_W'(1);
                end
                else
                begin
                    header_index_next = header_index_reg + spbd_pkg::HDR_IDX_W'(1);
                end
            end

            // reload while a packet is partial, otherwise stop
            if ((bytes_remaining_next != '0) || (header_index_next != '0))
            begin
                watchdog_count_next   = timeout_reg;
                watchdog_running_next = 1'b1;
            end
            else
            begin
                watchdog_count_next   = '0;
                watchdog_running_next = 1'b0;
            end
        end
    end

    // items with no result never wait for the output side
    assign advance   = item_valid && (!produce || res_ready);
    assign res_valid = item_valid && produce && res_ready;

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_index_reg     <= '0;
            length_shift_reg     <= '0;
            bytes_remaining_reg  <= '0;
            watchdog_count_reg   <= '0;
            watchdog_running_reg <= 1'b0;
        end
        else if (advance)
        begin
            header_index_reg     <= header_index_next;
            length_shift_reg     <= length_shift_next;
            bytes_remaining_reg  <= bytes_remaining_next;
            watchdog_count_reg   <= watchdog_count_next;
            watchdog_running_reg <= watchdog_running_next;
        end
    end

    // checks on parser state
    `SPBD_ASSERT_ALWAYS(a_hdr_range, clk, rst_n, header_index_reg <= spbd_pkg::HDR_LAST_IDX, "header index past last header byte")
    `SPBD_ASSERT_IMPL(a_hdr_or_body, clk, rst_n, header_index_reg != '0, bytes_remaining_reg == '0, "header and payload counting at once")
    `SPBD_ASSERT_ALWAYS(a_wd_partial, clk, rst_n, watchdog_running_reg == ((header_index_reg != '0) || (bytes_remaining_reg != '0)), "watchdog state disagrees with partial packet")
    `SPBD_ASSERT_NEXT(a_wd_expire, clk, rst_n, advance && (item.mode == spbd_pkg::MODE_TICK) && expire, !watchdog_running_reg && (watchdog_count_reg == '0), "watchdog still armed after abort")

endmodule

`default_nettype wire

/* hdl/spbd_out_stage.sv */
// output register holding one result item until taken
`default_nettype none

module spbd_out_stage
(
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   res_valid,
    output logic                  res_ready,
    input  spbd_pkg::spbd_result_t res,
    output logic                  dn_valid,
    input  wire                   dn_ready,
    output spbd_pkg::spbd_result_t dn_res
);

    logic                   valid_reg;
    logic                   valid_next;
    spbd_pkg::spbd_result_t res_reg;

    // room when empty or when the held result is taken this cycle
    assign res_ready  = !valid_reg || dn_ready;
    assign valid_next = res_ready ? res_valid : valid_reg;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            res_reg <= res;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_res   = res_reg;

endmodule

`default_nettype wire

/* verif/space_packet_byte_deframer_test.sv */
// self-checking testbench of the space packet byte deframer
`default_nettype none

module space_packet_byte_deframer_test;

    localparam int unsigned DRAIN_CYCLES     = 6;
    localparam int unsigned LONG_HOLD_CYCLES = 400;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    spbd_in_if  in_ch ();
    spbd_out_if out_ch ();
    spbd_cfg_if cfg_ch ();

    space_packet_byte_deframer dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (in_ch),
        .out   (out_ch),
        .cfg   (cfg_ch)
    );

    // stimulus and expectation stores
    spbd_pkg::spbd_item_t   pending_items[$];
    spbd_pkg::spbd_result_t expected_results[$];

    // sender and receiver drive registers
    logic                   drv_valid = 1'b0;
    spbd_pkg::spbd_item_t   cur_item  = '0;
    logic                   mon_ready = 1'b0;
    logic                   hold_start = 1'b0;
    int unsigned            hold_left;
    int unsigned            gap_left;
    int unsigned            stall_left;
    bit                     calm = 1'b0;
    int                     fail_count = 0;
    spbd_pkg::spbd_result_t got_result;
    spbd_pkg::spbd_result_t want_result;

    assign in_ch.valid  = drv_valid;
    assign in_ch.mode   = cur_item.mode;
    assign in_ch.data   = cur_item.data;
    assign out_ch.ready = mon_ready;

    // own copy of the parser, watchdog and timeout register
    logic [spbd_pkg::HDR_IDX_W-1:0] hdr_count   = '0;
    logic [spbd_pkg::LENGTH_W-1:0]  len_shift   = '0;
    logic [spbd_pkg::REMAIN_W-1:0]  remain      = '0;
    logic [spbd_pkg::TIMEOUT_W-1:0] wd_count    = '0;
    bit                             wd_running  = 1'b0;
    logic [spbd_pkg::TIMEOUT_W-1:0] tmo_setting = spbd_pkg::TIMEOUT_RESET;

    initial
    begin
        forever #5 clk = ~clk;
    end

    // work out the result of one accepted item and queue it
    function automatic void predict_deframe(input spbd_pkg::spbd_item_t it);
        spbd_pkg::spbd_result_t r;
        r = '0;
        if (it.mode == spbd_pkg::MODE_TICK)
        begin
            if (wd_running)
            begin
                if (wd_count <= 1)
                begin
                    // watchdog expiry aborts the partial packet
                    wd_count   = '0;
                    wd_running = 1'b0;
                    hdr_count  = '0;
                    remain     = '0;
                    r.kind     = spbd_pkg::KIND_ABORT;
                    expected_results.push_back(r);
                end
                else
                    wd_count = wd_count - 1'b1;
            end
        end
        else
        begin
            len_shift = {len_shift[7:0], it.data};
            if (remain != 0)
            begin
                remain = remain - 1'b1;
                r.last = (remain == 0);
            end
            else
            begin
                r.in_header = 1'b1;
                hdr_count   = hdr_count + 1'b1;
                if (hdr_count >= spbd_pkg::HDR_IDX_W'(spbd_pkg::HEADER_BYTES))
                begin
                    remain    = {1'b0, len_shift} + 1'b1;
                    hdr_count = '0;
                end
            end
            // reload while anything is partial, else stop and clear
            if (remain != 0 || hdr_count != 0)
            begin
                wd_count   = tmo_setting;
                wd_running = 1'b1;
            end
            else
            begin
                wd_count   = '0;
                wd_running = 1'b0;
            end
            r.kind     = spbd_pkg::KIND_BYTE;
            r.byte_out = it.data;
            expected_results.push_back(r);
        end
    endfunction

    // sender: offers pending items with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drv_valid <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (drv_valid && in_ch.ready)
                predict_deframe(cur_item);
            if (!drv_valid || !in_ch.ready)
            begin
                if (!drv_valid)
                begin
                    if (gap_left != 0)
                        gap_left--;
                    else if (pending_items.size() != 0)
                    begin
                        cur_item  <= pending_items.pop_front();
                        drv_valid <= 1'b1;
                        if (!calm && $urandom_range(0, 5) == 0)
                            gap_left = $urandom_range(1, 5);
                    end
                end
            end
            else
            begin
                // item taken at this edge
                if (gap_left == 0 && pending_items.size() != 0)
                begin
                    cur_item <= pending_items.pop_front();
                    if (!calm && $urandom_range(0, 5) == 0)
                        gap_left = $urandom_range(1, 5);
                end
                else
                    drv_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off, counted here
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_start)
            hold_left <= LONG_HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // receiver: checks each result against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mon_ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_ch.valid && mon_ready)
            begin
                got_result.kind      = spbd_pkg::spbd_kind_t'(out_ch.kind);
                got_result.byte_out  = out_ch.byte_out;
                got_result.last      = out_ch.last;
                got_result.in_header = out_ch.in_header;
                if (expected_results.size() == 0)
                begin
                    $error("result with nothing expected: kind %0d byte_out %02h",
                           got_result.kind, got_result.byte_out);
                    fail_count++;
                end
                else
                begin
                    want_result = expected_results.pop_front();
                    if (got_result.kind !== want_result.kind)
                    begin
                        $error("kind: expected %0d, actual %0d",
                               want_result.kind, got_result.kind);
                        fail_count++;
                    end
                    if (got_result.byte_out !== want_result.byte_out)
                    begin
                        $error("byte_out: expected %02h, actual %02h",
                               want_result.byte_out, got_result.byte_out);
                        fail_count++;
                    end
                    if (got_result.last !== want_result.last)
                    begin
                        $error("last: expected %0d, actual %0d",
                               want_result.last, got_result.last);
                        fail_count++;
                    end
                    if (got_result.in_header !== want_result.in_header)
                    begin
                        $error("in_header: expected %0d, actual %0d",
                               want_result.in_header, got_result.in_header);
                        fail_count++;
                    end
                end
            end
            if (hold_left != 0)
                mon_ready <= 1'b0;
            else if (stall_left != 0)
            begin
                stall_left--;
                mon_ready <= 1'b0;
            end
            else
            begin
                mon_ready <= 1'b1;
                if (!calm && $urandom_range(0, 5) == 0)
                    stall_left = $urandom_range(1, 5);
            end
        end
    end

    task automatic add_byte(input logic [7:0] b);
        pending_items.push_back('{mode: spbd_pkg::MODE_BYTE, data: b});
    endtask

    task automatic add_ticks(input int unsigned n);
        repeat (n) pending_items.push_back('{mode: spbd_pkg::MODE_TICK, data: 8'($urandom)});
    endtask

    // sender waits until every expected result is in and the pipe is empty
    task automatic wait_drained();
        while (pending_items.size() != 0 || drv_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_timeout(input logic [spbd_pkg::TIMEOUT_W-1:0] v);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= v;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        tmo_setting = v;
    endtask

    // mostly well-formed packets and noise; cut packets only for a short timeout
    task automatic add_random_traffic(input int unsigned budget,
                                      input logic [spbd_pkg::TIMEOUT_W-1:0] tmo);
        int unsigned eff;
        int unsigned made;
        int unsigned sel;
        int unsigned len;
        int unsigned cut;
        bit short_wd;
        eff = (tmo == 0) ? 1 : tmo;
        short_wd = (eff <= 50);
        made = 0;
        while (made < budget)
        begin
            sel = $urandom_range(0, 9);
            if (sel <= 6 || (!short_wd && sel <= 8))
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                  : $urandom_range(0, 12);
                repeat (4) add_byte(8'($urandom));
                add_byte(8'h00);
                add_byte(8'(len));
                for (int i = 0; i <= int'(len); i++)
                begin
                    // ticks inside a packet stay short of expiry
                    if (eff > 1 && $urandom_range(0, 5) == 0)
                        add_ticks($urandom_range(1, (eff - 1 < 6) ? eff - 1 : 6));
                    add_byte(8'($urandom));
                end
                made += len + 7;
            end
            else if (sel == 7)
            begin
                cut = $urandom_range(1, 8);
                repeat (cut) add_byte(8'($urandom));
                add_ticks(eff + 1);
                made += cut + 1;
            end
            else if (sel == 8)
            begin
                cut = $urandom_range(1, 12);
                for (int i = 0; i < int'(cut); i++)
                    add_byte((i == 4) ? 8'h00 : (i == 5) ? 8'h08 : 8'($urandom));
                add_ticks(eff + $urandom_range(0, 2));
                made += cut + 1;
            end
            else
                add_ticks($urandom_range(1, 4));
        end
    endtask

    initial
    begin
        logic [spbd_pkg::TIMEOUT_W-1:0] tmo;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ticks while stopped, then a one-byte-payload packet of extreme bytes
        add_ticks(2);
        add_byte(8'hFF); add_byte(8'h00); add_byte(8'hFF);
        add_byte(8'h00); add_byte(8'h00); add_byte(8'h00);
        add_byte(8'hFF);
        // three-byte payload
        add_byte(8'h00); add_byte(8'hFF); add_byte(8'h00);
        add_byte(8'hFF); add_byte(8'h00); add_byte(8'h02);
        add_byte(8'h00); add_byte(8'hA5); add_byte(8'hFF);
        // header left partial, watchdog armed at the reset timeout
        add_byte(8'h12); add_byte(8'h34); add_byte(8'h56);
        wait_drained();

        // new timeout while armed only takes effect at the next reload
        write_timeout(16'd0);
        add_ticks(1000);
        // zero timeout expires on the first tick
        add_byte(8'h01); add_byte(8'h02);
        add_ticks(1);
        // largest length field, cut short by the watchdog
        add_byte(8'hAA); add_byte(8'h55); add_byte(8'hC3);
        add_byte(8'h3C); add_byte(8'hFF); add_byte(8'hFF);
        add_byte(8'h81); add_byte(8'h7E);
        add_ticks(1);
        // length shift survives the abort, header restarts
        add_byte(8'h7E);
        add_ticks(1);
        wait_drained();

        // longest timeout reloads at the top count and runs down part way
        write_timeout(16'hFFFF);
        add_byte(8'h5A); add_byte(8'hA5); add_byte(8'h0F);
        add_ticks(20);
        add_byte(8'h00);
        add_ticks(20);
        wait_drained();

        // random phases over several timeout settings
        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0: tmo = 16'd1;
                1: tmo = 16'd0;
                2: tmo = 16'hFFFF;
                3: tmo = 16'd5;
                4: tmo = 16'($urandom_range(2, 40));
                default: tmo = 16'd3;
            endcase
            write_timeout(tmo);
            if (p == 3)
            begin
                // receiver holds off while the sender keeps offering
                hold_start <= 1'b1;
                @(posedge clk);
                hold_start <= 1'b0;
            end
            if (p == 5)
                calm = 1'b1;
            add_random_traffic(25, tmo);
            wait_drained();
        end

        // back to the reset value at the end
        write_timeout(spbd_pkg::TIMEOUT_RESET);
        add_byte(8'hC0); add_byte(8'h3F);
        add_ticks(3);
        wait_drained();

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // run limit
    initial
    begin
        #20000000;
        $error("run did not drain in time");
        $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
